[src/scbw_pkg.sv]
// Shared types, widths and helper functions for the sprite coverage blender.
// No dependencies; every other file of the block imports this package.
package scbw_pkg;

	// Field widths of the pixel stream and the register file
	localparam int PIX_W  = 16;
	localparam int COV_W  = 4;
	localparam int COL_W  = 10;
	localparam int ROLE_W = 2;
	localparam int EDGE_W = 11;
	localparam int SOFT_W = 10;
	localparam int REG_W  = 16;
	localparam int REG_IDX_W = 3;

	// Panel width in columns; columns at or beyond it are not drawn
	localparam int PANEL_WIDTH = 1024;

	// Pipeline depth: stage 1 front end, stages 2-5 divider, stages 6-9 blend
	localparam int NUM_STAGES = 9;

	// Role codes of the input item
	localparam logic [ROLE_W-1:0] ROLE_INK = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_DIM = 2'd1;

	// Register indexes of the configuration port
	typedef enum logic [REG_IDX_W-1:0] {
		REG_INK    = 3'd0,
		REG_DIM    = 3'd1,
		REG_ACCENT = 3'd2,
		REG_EDGE   = 3'd3,
		REG_SOFT   = 3'd4
	} reg_idx_t;

	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	typedef struct packed {
		logic [PIX_W-1:0]  ink;
		logic [PIX_W-1:0]  dim;
		logic [PIX_W-1:0]  accent;
		logic [EDGE_W-1:0] edge_col;
		logic [SOFT_W-1:0] soft_width;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  base_pixel;
		logic [COV_W-1:0]  coverage;
		logic [COL_W-1:0]  column;
		logic [ROLE_W-1:0] role;
		logic              in_wipe;
	} in_item_t;

	// Item data that rides alongside the wipe divider
	typedef struct packed {
		logic [PIX_W-1:0] base;
		logic [PIX_W-1:0] ink;
		logic [7:0]       cov17;
		logic             pass;      // leave the base pixel untouched
		logic             fac_zero;  // wipe factor is zero
		logic             fac_full;  // wipe factor is 256
	} side_t;

	// Expand RGB565 to 8 bits per channel by bit replication: {r8, g8, b8}
	function automatic logic [23:0] widen565(logic [PIX_W-1:0] c);
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		r5 = c[15:11];
		g6 = c[10:5];
		b5 = c[4:0];
		return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
	endfunction

	// Round an 8-bit channel to 5 bits, saturating at the top code
	function automatic logic [4:0] narrow5(logic [7:0] v);
		logic [8:0] t;
		t = {1'b0, v} + 9'd4;
		return t[8] ? 5'h1F : t[7:3];
	endfunction

	// Round an 8-bit channel to 6 bits, saturating at the top code
	function automatic logic [5:0] narrow6(logic [7:0] v);
		logic [8:0] t;
		t = {1'b0, v} + 9'd2;
		return t[8] ? 6'h3F : t[7:2];
	endfunction

endpackage

[src/scbw_in_if.sv]
// Input pixel channel: valid/ready handshake with the pixel item as payload.
// Depends on scbw_pkg for the field widths.
interface scbw_in_if import scbw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  base_pixel;
	logic [COV_W-1:0]  coverage;
	logic [COL_W-1:0]  column;
	logic [ROLE_W-1:0] role;
	logic              in_wipe;

	modport source(output valid, base_pixel, coverage, column, role, in_wipe, input ready);
	modport sink(input valid, base_pixel, coverage, column, role, in_wipe, output ready);
endinterface

[src/scbw_out_if.sv]
// Output pixel channel: valid/ready handshake carrying the blended pixel.
// Depends on scbw_pkg for the pixel width.
interface scbw_out_if import scbw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source(output valid, pixel_out, input ready);
	modport sink(input valid, pixel_out, output ready);
endinterface

[src/scbw_cfg_regs.sv]
// Configuration register file: ink colours and wipe edge/soft width.
// Depends on scbw_pkg for cfg_t and the register index codes.
module scbw_cfg_regs import scbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INK:    cfg_q.ink        <= cfg_wdata;
				REG_DIM:    cfg_q.dim        <= cfg_wdata;
				REG_ACCENT: cfg_q.accent     <= cfg_wdata;
				REG_EDGE:   cfg_q.edge_col   <= cfg_wdata[EDGE_W-1:0];
				REG_SOFT:   cfg_q.soft_width <= cfg_wdata[SOFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/scbw_front.sv]
// Stage 1: ink selection by role and classification of the wipe factor.
// Depends on scbw_pkg for in_item_t, side_t and cfg_t.
module scbw_front import scbw_pkg::*; (
	input  logic             clk,
	input  stage_vec_t       en,
	input  cfg_t             cfg,
	input  in_item_t         item,
	output side_t            side_s1,
	output logic [SOFT_W-1:0] rem_s1
);

	side_t             side_d;
	logic [EDGE_W-1:0] col_x;
	logic [EDGE_W:0]   reach;
	logic [EDGE_W-1:0] edge_gap;

	// Pick the ink and decide where the column sits against the wipe edge
	always_comb begin
		col_x    = {1'b0, item.column};
		reach    = {2'b00, item.column} + {2'b00, cfg.soft_width};
		edge_gap = cfg.edge_col - col_x;

		side_d.base  = item.base_pixel;
		side_d.cov17 = {item.coverage, item.coverage};
		side_d.pass  = (item.coverage == '0) || (int'(item.column) >= PANEL_WIDTH);
		unique case (item.role)
			ROLE_INK: side_d.ink = cfg.ink;
			ROLE_DIM: side_d.ink = cfg.dim;
			default:  side_d.ink = cfg.accent;
		endcase
		side_d.fac_zero = item.in_wipe && (col_x >= cfg.edge_col);
		side_d.fac_full = !item.in_wipe || (cfg.soft_width == '0) ||
			(reach <= {1'b0, cfg.edge_col});
	end

	// Register stage 1; inside the soft band the distance is below soft
	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1 <= side_d;
			rem_s1  <= edge_gap[SOFT_W-1:0];
		end
	end

endmodule

[src/scbw_wipe_div.sv]
// Stages 2-5: restoring divider for (distance * 256) / soft, two quotient
// bits per stage. Depends on scbw_pkg for side_t and stage_vec_t.
module scbw_wipe_div import scbw_pkg::*; (
	input  logic              clk,
	input  stage_vec_t        en,
	input  logic [SOFT_W-1:0] soft_width,
	input  side_t             side_s1,
	input  logic [SOFT_W-1:0] rem_s1,
	output side_t             side_s5,
	output logic [7:0]        quo_s5
);

	// One restoring step: {quotient bit, new remainder}
	function automatic logic [SOFT_W:0] div_step(logic [SOFT_W-1:0] r, logic [SOFT_W-1:0] s);
		logic [SOFT_W:0] r2;
		logic [SOFT_W:0] diff;
		r2   = {r, 1'b0};
		diff = r2 - {1'b0, s};
		if (r2 >= {1'b0, s}) begin
			return {1'b1, diff[SOFT_W-1:0]};
		end
		return {1'b0, r2[SOFT_W-1:0]};
	endfunction

	// Two steps: {two quotient bits, remainder}
	function automatic logic [SOFT_W+1:0] two_steps(logic [SOFT_W-1:0] r, logic [SOFT_W-1:0] s);
		logic [SOFT_W:0] a;
		logic [SOFT_W:0] b;
		a = div_step(r, s);
		b = div_step(a[SOFT_W-1:0], s);
		return {a[SOFT_W], b[SOFT_W], b[SOFT_W-1:0]};
	endfunction

	logic [SOFT_W+1:0] st2, st3, st4, st5;
	side_t             side_s2, side_s3, side_s4;
	logic [SOFT_W-1:0] rem_s2, rem_s3, rem_s4;
	logic [7:0]        quo_s2, quo_s3, quo_s4;

	assign st2 = two_steps(rem_s1, soft_width);
	assign st3 = two_steps(rem_s2, soft_width);
	assign st4 = two_steps(rem_s3, soft_width);
	assign st5 = two_steps(rem_s4, soft_width);

	// Advance the divider stages; quotient bits shift in from the right
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= side_s1;
			rem_s2  <= st2[SOFT_W-1:0];
			quo_s2  <= {6'd0, st2[SOFT_W+1:SOFT_W]};
		end
		if (en[2]) begin
			side_s3 <= side_s2;
			rem_s3  <= st3[SOFT_W-1:0];
			quo_s3  <= {quo_s2[5:0], st3[SOFT_W+1:SOFT_W]};
		end
		if (en[3]) begin
			side_s4 <= side_s3;
			rem_s4  <= st4[SOFT_W-1:0];
			quo_s4  <= {quo_s3[5:0], st4[SOFT_W+1:SOFT_W]};
		end
		if (en[4]) begin
			side_s5 <= side_s4;
			quo_s5  <= {quo_s4[5:0], st5[SOFT_W+1:SOFT_W]};
		end
	end

endmodule

[src/scbw_blend.sv]
// Stages 6-9: alpha from coverage and wipe factor, per-channel interpolation
// with an exact divide by 255, rounding back to RGB565. Depends on scbw_pkg.
module scbw_blend import scbw_pkg::*; (
	input  logic             clk,
	input  stage_vec_t       en,
	input  side_t            side_s5,
	input  logic [7:0]       quo_s5,
	output logic [PIX_W-1:0] pix_s9
);

	// Stage 6 signals
	logic [8:0]       factor;
	logic [16:0]      aprod;
	logic [7:0]       alpha_s6;
	logic [PIX_W-1:0] base_s6, ink_s6;
	logic             pass_s6;

	// Stage 7 signals
	logic [23:0]      b24, c24;
	logic [15:0]      m_d [3];
	logic             neg_d [3];
	logic [15:0]      m_s7 [3];
	logic             neg_s7 [3];
	logic [7:0]       b8_s7 [3];
	logic             sel_base_s7, sel_ink_s7;
	logic [PIX_W-1:0] base_s7, ink_s7;

	// Stage 8 signals
	logic [7:0]       q0_d [3];
	logic [7:0]       q0_s8 [3];
	logic [15:0]      m_s8 [3];
	logic             neg_s8 [3];
	logic [7:0]       b8_s8 [3];
	logic             sel_base_s8, sel_ink_s8;
	logic [PIX_W-1:0] base_s8, ink_s8;

	// Stage 9 signals
	logic [7:0]       v_d [3];
	logic [PIX_W-1:0] mix_pix;

	// Stage 6: scale coverage by the wipe factor
	always_comb begin
		if (side_s5.fac_zero) begin
			factor = 9'd0;
		end else if (side_s5.fac_full) begin
			factor = 9'd256;
		end else begin
			factor = {1'b0, quo_s5};
		end
		aprod = 17'(side_s5.cov17) * 17'(factor);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			alpha_s6 <= aprod[15:8];
			base_s6  <= side_s5.base;
			ink_s6   <= side_s5.ink;
			pass_s6  <= side_s5.pass;
		end
	end

	// Stage 7: widen, take the channel difference magnitude and scale by alpha
	always_comb begin
		logic [7:0] bc, cc, mag;
		b24 = widen565(base_s6);
		c24 = widen565(ink_s6);
		for (int c = 0; c < 3; c++) begin
			bc = b24[8*c +: 8];
			cc = c24[8*c +: 8];
			neg_d[c] = cc < bc;
			mag = neg_d[c] ? (bc - cc) : (cc - bc);
			m_d[c] = 16'(mag) * 16'(alpha_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int c = 0; c < 3; c++) begin
				m_s7[c]   <= m_d[c];
				neg_s7[c] <= neg_d[c];
				b8_s7[c]  <= b24[8*c +: 8];
			end
			sel_base_s7 <= pass_s6 || (alpha_s6 == 8'd0);
			sel_ink_s7  <= (alpha_s6 == 8'hFF);
			base_s7     <= base_s6;
			ink_s7      <= ink_s6;
		end
	end

	// Stage 8: quotient estimate m*257 >> 16, low by at most one
	always_comb begin
		logic [23:0] est;
		for (int c = 0; c < 3; c++) begin
			est = {m_s7[c], 8'd0} + {8'd0, m_s7[c]};
			q0_d[c] = est[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int c = 0; c < 3; c++) begin
				q0_s8[c]  <= q0_d[c];
				m_s8[c]   <= m_s7[c];
				neg_s8[c] <= neg_s7[c];
				b8_s8[c]  <= b8_s7[c];
			end
			sel_base_s8 <= sel_base_s7;
			sel_ink_s8  <= sel_ink_s7;
			base_s8     <= base_s7;
			ink_s8      <= ink_s7;
		end
	end

	// Stage 9: correct the quotient, apply it toward the ink, round to 565
	always_comb begin
		logic [15:0] back;
		logic [15:0] r;
		logic [8:0]  q;
		logic [8:0]  v;
		for (int c = 0; c < 3; c++) begin
			back = {q0_s8[c], 8'd0} - {8'd0, q0_s8[c]};
			r = m_s8[c] - back;
			q = {1'b0, q0_s8[c]} + ((r >= 16'd255) ? 9'd1 : 9'd0);
			v = neg_s8[c] ? ({1'b0, b8_s8[c]} - q) : ({1'b0, b8_s8[c]} + q);
			v_d[c] = v[7:0];
		end
		mix_pix = {narrow5(v_d[2]), narrow6(v_d[1]), narrow5(v_d[0])};
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			priority if (sel_base_s8) begin
				pix_s9 <= base_s8;
			end else if (sel_ink_s8) begin
				pix_s9 <= ink_s8;
			end else begin
				pix_s9 <= mix_pix;
			end
		end
	end

endmodule

[src/sprite_coverage_blend_with_wipe_top.sv]
// Sprite coverage blender with layer wipe, RGB565.
//
// Usage: pixels enter on pix_in (valid/ready) with the base pixel, the 4-bit
// sprite coverage, the column, the ink role and the wipe flag; the blended
// pixel leaves on pix_out (valid/ready). The colour and wipe registers are
// written through cfg_we/cfg_index/cfg_wdata while no pixel is in flight.
//
// Throughput: one pixel per clock, sustained while pix_out is ready.
// Latency: nine register stages, set by the wipe divider (four stages, two
// quotient bits each) and the blend (alpha multiply, channel multiply, divide
// by 255 and round).
//
// Reset (arst_n low) clears the configuration registers to zero and the
// stage valid bits, which empties the pipeline.
// When the receiver stalls, the last stage holds its pixel; earlier stages
// keep moving into empty slots, and pix_in.ready drops only once all nine
// stages are full. Nothing is lost or repeated across a stall.
// Depends on scbw_pkg, scbw_in_if, scbw_out_if and the scbw_* stage modules.
module sprite_coverage_blend_with_wipe_top import scbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	scbw_in_if.sink              pix_in,
	scbw_out_if.source           pix_out
);

	cfg_t              cfg;
	in_item_t          item;
	stage_vec_t        en;
	stage_vec_t        vld_q;
	side_t             side_s1, side_s5;
	logic [SOFT_W-1:0] rem_s1;
	logic [7:0]        quo_s5;
	logic [PIX_W-1:0]  pix_s9;

	scbw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Gather the input payload
	assign item = '{
		base_pixel: pix_in.base_pixel,
		coverage:   pix_in.coverage,
		column:     pix_in.column,
		role:       pix_in.role,
		in_wipe:    pix_in.in_wipe
	};

	// A stage advances when it is empty or the stage after it advances
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || pix_out.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= pix_in.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	scbw_front u_front (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg),
		.item    (item),
		.side_s1 (side_s1),
		.rem_s1  (rem_s1)
	);

	scbw_wipe_div u_div (
		.clk        (clk),
		.en         (en),
		.soft_width (cfg.soft_width),
		.side_s1    (side_s1),
		.rem_s1     (rem_s1),
		.side_s5    (side_s5),
		.quo_s5     (quo_s5)
	);

	scbw_blend u_blend (
		.clk     (clk),
		.en      (en),
		.side_s5 (side_s5),
		.quo_s5  (quo_s5),
		.pix_s9  (pix_s9)
	);

	assign pix_in.ready      = en[0];
	assign pix_out.valid     = vld_q[NUM_STAGES-1];
	assign pix_out.pixel_out = pix_s9;

`ifndef SYNTHESIS
	// Input back-pressure only when every stage holds a pixel
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (vld_q == '1))
		else $error("input stalled with an empty pipeline stage");

	// A stalled first stage keeps its pixel
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[0] && !en[0]) |=> vld_q[0])
		else $error("stage 1 pixel lost during a stall");

	// A pixel leaving the last stage is replaced by the one behind it
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.ready) |=> (vld_q[NUM_STAGES-1] == $past(vld_q[NUM_STAGES-2])))
		else $error("output stage did not take the pixel behind it");
`endif

endmodule
